// ===== src/postfix_stack_evaluator_unit_macros.svh =====
// Assertion macros shared by the postfix evaluator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_MACROS_SVH
`ifndef SYNTH
// Check a condition at every clock edge outside reset.
`define PSE_ASSERT(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");
// Check that an antecedent is followed by a consequent in the next cycle.
`define PSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSE_ASSERT(lbl, clk, rstn, cond)
`define PSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/pse_pkg.sv =====
// Shared types, token and status codes and sizes of the postfix evaluator.
// No dependencies; imported by every module of the block but pse_ram.
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;

  localparam int STACK_DEPTH_DEFAULT = 128;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_SUB     = 3'd2;
  localparam logic [2:0] OP_MUL     = 3'd3;
  localparam logic [2:0] OP_DIV     = 3'd4;
  localparam logic [2:0] OP_MOD     = 3'd5;
  localparam logic [2:0] OP_END     = 3'd6;
  localparam logic [2:0] OP_ILLEGAL = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FEW      = 3'd1;
  localparam logic [2:0] ST_DIVZERO  = 3'd2;
  localparam logic [2:0] ST_ILLEGAL  = 3'd3;
  localparam logic [2:0] ST_MANY     = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;

  // Shared divider; a divide's dividend is the Q16.16 magnitude << 16.
  localparam int DIV_DVD_W  = 48;
  localparam int DIV_DSR_W  = 32;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = DIV_DVD_W / DIV_STEPS;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] number_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_PUSH,
    KIND_ARITH,
    KIND_END,
    KIND_BAD
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [2:0]         op;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quotient;
    logic [DIV_DSR_W-1:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/pse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/pse_divider.sv =====
// Iterative unsigned restoring divider, DIV_STEPS bits per cycle.
// Depends on pse_pkg for widths and request/response structs.
`timescale 1ns / 1ps
`default_nettype none
module pse_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pse_pkg::div_req_t req_i,
  output pse_pkg::div_rsp_t      rsp_o
);
  import pse_pkg::*;

  localparam int CW = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  logic                 busy_q, done_q;
  logic [CW-1:0]        cnt_q;
  logic [DIV_DSR_W-1:0] rem_q, rem_n, dsr_q;
  logic [DIV_DVD_W-1:0] dvd_q, dvd_n;
  logic [DIV_DSR_W:0]   trial;

  // Shift in one dividend bit, subtract when it fits, per step.
  always_comb begin
    rem_n = rem_q;
    dvd_n = dvd_q;
    trial = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_n, dvd_n[DIV_DVD_W-1]};
      dvd_n = {dvd_n[DIV_DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        trial    = trial - {1'b0, dsr_q};
        dvd_n[0] = 1'b1;
      end
      rem_n = trial[DIV_DSR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DIV_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= rem_n;
      dvd_q <= dvd_n;
    end else if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule
`default_nettype wire

// ===== src/pse_front.sv =====
// Front end: accepts tokens, classifies them and queues them for execution.
// Depends on pse_pkg for the item, command and code definitions.
`timescale 1ns / 1ps
`default_nettype none
module pse_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pse_pkg::in_item_t in_data_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output pse_pkg::cmd_t          cmd_o
);
  import pse_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          cls;
  cmd_t          q_mem [QUEUE_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [FW-1:0] fill_q;
  logic          push, pop;

  // Classify the token; keep the operand only where it is used.
  always_comb begin
    cls.op    = in_data_i.operation;
    cls.value = '0;
    unique case (in_data_i.operation)
      OP_PUSH: begin
        cls.kind  = KIND_PUSH;
        cls.value = in_data_i.number_value;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: cls.kind = KIND_ARITH;
      OP_END:  cls.kind = KIND_END;
      default: cls.kind = KIND_BAD;
    endcase
  end

  assign in_ready_o  = (fill_q != FW'(QUEUE_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = q_mem[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + PW'(1);
      if (pop)  rptr_q <= rptr_q + PW'(1);
      unique case ({push, pop})
        2'b10:   fill_q <= fill_q + FW'(1);
        2'b01:   fill_q <= fill_q - FW'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== src/pse_back.sv =====
// Back end: operand stack, arithmetic, error latch and the result register.
// Depends on pse_pkg, pse_ram, pse_divider and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "postfix_stack_evaluator_unit_macros.svh"
module pse_back #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEFAULT
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  wire pse_pkg::cmd_t  cmd_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output pse_pkg::out_item_t  out_data_o
);
  import pse_pkg::*;

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_FETCH  = 2'd0;
  localparam logic [1:0] S_MUL    = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_REFILL = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d, cnt_m2, cnt_m3;
  logic [2:0]         err_q, err_d;
  logic signed [31:0] tos_q, tos_d, nos_q, nos_d;
  logic signed [63:0] prod_q, prod_d;
  logic               mod_q, mod_d, neg_q, neg_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;

  logic               fin_valid;
  logic signed [31:0] fin_value;
  logic               ram_we, ram_re;
  logic [31:0]        ram_rdata;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [31:0]        lmag, rmag;
  logic signed [15:0] li, ri;
  logic [15:0]        limag, rimag;
  logic signed [49:0] qsigned;
  logic signed [16:0] msigned;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  pse_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_m2[AW-1:0]),
    .wdata_i(nos_q),
    .re_i   (ram_re),
    .raddr_i(cnt_m3[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  pse_divider u_divider (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign cnt_m2 = count_q - CNT_W'(2);
  assign cnt_m3 = count_q - CNT_W'(3);

  // Operand magnitudes and truncated integer parts for divide and modulo.
  always_comb begin
    lmag  = nos_q[31] ? (~nos_q + 32'd1) : nos_q;
    rmag  = tos_q[31] ? (~tos_q + 32'd1) : tos_q;
    li    = nos_q[31:16] + {15'd0, nos_q[31] && (nos_q[15:0] != '0)};
    ri    = tos_q[31:16] + {15'd0, tos_q[31] && (tos_q[15:0] != '0)};
    limag = li[15] ? (~li + 16'd1) : li;
    rimag = ri[15] ? (~ri + 16'd1) : ri;
  end

  always_comb begin
    qsigned = neg_q ? -$signed({2'b00, div_rsp.quotient})
                    :  $signed({2'b00, div_rsp.quotient});
    msigned = neg_q ? -$signed({1'b0, div_rsp.remainder[15:0]})
                    :  $signed({1'b0, div_rsp.remainder[15:0]});
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    err_d       = err_q;
    tos_d       = tos_q;
    nos_d       = nos_q;
    prod_d      = prod_q;
    mod_d       = mod_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    cmd_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    fin_valid   = 1'b0;
    fin_value   = '0;
    div_req.start    = 1'b0;
    div_req.dividend = (cmd_i.op == OP_MOD) ? DIV_DVD_W'(limag) : {lmag, 16'd0};
    div_req.divisor  = (cmd_i.op == OP_MOD) ? DIV_DSR_W'(rimag) : rmag;

    unique case (state_q)
      S_FETCH: begin
        if (cmd_valid_i) begin
          priority if (cmd_i.kind == KIND_END) begin
            if (!out_valid_q || out_ready_i) begin
              cmd_ready_o = 1'b1;
              out_valid_d = 1'b1;
              out_data_d.result_value = '0;
              priority if (err_q != ST_OK) begin
                out_data_d.status = err_q;
              end else if (count_q == '0) begin
                out_data_d.status = ST_EMPTY;
              end else if (count_q == CNT_W'(1)) begin
                out_data_d.status       = ST_OK;
                out_data_d.result_value = tos_q;
              end else begin
                out_data_d.status = ST_MANY;
              end
              count_d = '0;
              err_d   = ST_OK;
            end
          end else if (err_q != ST_OK) begin
            cmd_ready_o = 1'b1;
          end else if (cmd_i.kind == KIND_PUSH) begin
            cmd_ready_o = 1'b1;
            if (count_q >= CNT_W'(STACK_DEPTH)) begin
              err_d = ST_OVERFLOW;
            end else begin
              ram_we  = (count_q >= CNT_W'(2));
              nos_d   = tos_q;
              tos_d   = cmd_i.value;
              count_d = count_q + CNT_W'(1);
            end
          end else if (count_q < CNT_W'(2)) begin
            cmd_ready_o = 1'b1;
            err_d       = ST_FEW;
          end else if (cmd_i.kind == KIND_BAD) begin
            cmd_ready_o = 1'b1;
            err_d       = ST_ILLEGAL;
          end else begin
            cmd_ready_o = 1'b1;
            unique case (cmd_i.op)
              OP_ADD: begin
                fin_valid = 1'b1;
                fin_value = sat32(64'(nos_q) + 64'(tos_q));
              end
              OP_SUB: begin
                fin_valid = 1'b1;
                fin_value = sat32(64'(nos_q) - 64'(tos_q));
              end
              OP_MUL: begin
                prod_d  = nos_q * tos_q;
                state_d = S_MUL;
              end
              OP_DIV: begin
                if (tos_q == '0) begin
                  err_d = ST_DIVZERO;
                end else begin
                  div_req.start = 1'b1;
                  mod_d   = 1'b0;
                  neg_d   = nos_q[31] ^ tos_q[31];
                  state_d = S_DIV;
                end
              end
              OP_MOD: begin
                if (ri == '0) begin
                  err_d = ST_DIVZERO;
                end else begin
                  div_req.start = 1'b1;
                  mod_d   = 1'b1;
                  neg_d   = li[15];
                  state_d = S_DIV;
                end
              end
              default: err_d = ST_ILLEGAL;
            endcase
          end
        end
      end
      S_MUL: begin
        // Arithmetic shift floors the product, as the format asks.
        fin_valid = 1'b1;
        fin_value = sat32(prod_q >>> 16);
      end
      S_DIV: begin
        if (div_rsp.done) begin
          fin_valid = 1'b1;
          fin_value = mod_q ? {msigned[15:0], 16'd0} : sat32(64'(qsigned));
        end
      end
      default: begin
        nos_d   = ram_rdata;
        state_d = S_FETCH;
      end
    endcase

    // Pop two, push one as new top; over 2 held, refill the second from RAM.
    if (fin_valid) begin
      tos_d   = fin_value;
      count_d = count_q - CNT_W'(1);
      if (count_q >= CNT_W'(3)) begin
        ram_re  = 1'b1;
        state_d = S_REFILL;
      end else begin
        state_d = S_FETCH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FETCH;
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q      <= tos_d;
    nos_q      <= nos_d;
    prod_q     <= prod_d;
    mod_q      <= mod_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `PSE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(STACK_DEPTH))
  `PSE_ASSERT(a_refill_depth, clk_i, rst_ni, state_q != S_REFILL || count_q >= CNT_W'(2))
  `PSE_ASSERT(a_div_start_fetch, clk_i, rst_ni, !div_req.start || state_q == S_FETCH)
  `PSE_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, cmd_valid_i && cmd_ready_o && cmd_i.kind == KIND_END, count_q == '0 && err_q == ST_OK && out_valid_q)

endmodule
`default_nettype wire

// ===== src/postfix_stack_evaluator_unit.sv =====
// Postfix (RPN) evaluator on signed Q16.16 values that saturate.
// Input channel in_valid_i/in_ready_o/in_data_i carries one token per
// transaction: push, + - * / %, an illegal operator, or end of expression.
// Output channel out_valid_o/out_ready_i/out_data_o carries one transaction
// per end token: the final value and a status code.
// Tokens enter a two-entry queue; the back end works on one at a time.
// In the back end, push, drop after an error, error detection, add/sub
// and the end token finish in the fetch state; multiply passes through a
// product state, and divide and modulo wait on the shared divider at 2
// quotient bits per cycle; an operator then refills the second stack entry
// from the stack RAM when 3 or more operands were held.
// An end token's result is registered when the back end takes the token.
// Reset empties the stack count, clears the latched error and the queue;
// stack RAM contents need no clearing since only filled entries are read.
// When the receiver stalls, the result holds in the output register and
// the block keeps taking tokens; only a following end token waits.
// Depends on pse_pkg, pse_front and pse_back.
`timescale 1ns / 1ps
`default_nettype none
module postfix_stack_evaluator_unit #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pse_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output pse_pkg::out_item_t     out_data_o
);
  import pse_pkg::*;

  // Classified token queue between the two halves.
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  pse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  // Stack, arithmetic and result register.
  pse_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_postfix_stack_evaluator_unit.sv =====
// Testbench for postfix_stack_evaluator_unit: directed token table, then random RPN expressions.
// Results are checked field by field against an in-bench Q16.16 evaluator or typed results.
// Depends on pse_pkg and the postfix_stack_evaluator_unit RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_postfix_stack_evaluator_unit;
  import pse_pkg::*;

  localparam int      DEPTH       = STACK_DEPTH_DEFAULT;
  localparam int      CYCLE_LIMIT = 200000;
  // Tail to watch for strays; covers the longest back-end token and the queue.
  localparam int      TAIL_CYCLES = 64;
  // Random tokens; the directed table sends about 180 more.
  localparam int      RAND_TOKENS = 320;
  localparam longint  Q_MAX       = 64'sd2147483647;
  localparam longint  Q_MIN       = -64'sd2147483648;

  // One row of the directed table: a token sent reps times, and for end
  // tokens optionally a result typed in by hand.
  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] val;
    int                 reps;
    bit                 typed;
    logic signed [31:0] exp_val;
    logic [2:0]         exp_st;
  } token_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  // Evaluator state mirrored in the bench.
  logic signed [31:0] eval_stack [DEPTH];
  int                 eval_count = 0;
  logic [2:0]         eval_err   = ST_OK;

  out_item_t  pending_results [$];
  token_row_t token_table [$];
  int         error_count    = 0;
  int         tokens_sent    = 0;
  int         cycle_count    = 0;
  bit         sender_idles   = 1'b1;
  bit         receiver_idles = 1'b1;

  postfix_stack_evaluator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Clamp a wide intermediate to the signed Q16.16 range.
  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > Q_MAX) return 32'sh7FFF_FFFF;
    if (v < Q_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Advance the mirrored evaluator by one token; return 1 when the token
  // yields a result, which is then placed in res.
  function automatic bit evaluate_token(input in_item_t tok, output out_item_t res);
    longint lhs, rhs, acc;
    int     li, ri;
    res = '0;
    if (tok.operation == OP_END) begin
      if (eval_err != ST_OK) res.status = eval_err;
      else if (eval_count == 0) res.status = ST_EMPTY;
      else if (eval_count == 1) begin
        res.status       = ST_OK;
        res.result_value = eval_stack[0];
      end else res.status = ST_MANY;
      eval_count = 0;
      eval_err   = ST_OK;
      return 1'b1;
    end
    // Drop every token after the first error until the end token.
    if (eval_err != ST_OK) return 1'b0;
    if (tok.operation == OP_PUSH) begin
      if (eval_count >= DEPTH) eval_err = ST_OVERFLOW;
      else begin
        eval_stack[eval_count] = tok.number_value;
        eval_count++;
      end
      return 1'b0;
    end
    if (eval_count < 2) begin
      eval_err = ST_FEW;
      return 1'b0;
    end
    rhs = eval_stack[eval_count-1];
    lhs = eval_stack[eval_count-2];
    case (tok.operation)
      OP_ADD: acc = lhs + rhs;
      OP_SUB: acc = lhs - rhs;
      // Arithmetic shift floors the product.
      OP_MUL: acc = (lhs * rhs) >>> 16;
      OP_DIV: begin
        if (rhs == 0) begin
          eval_err = ST_DIVZERO;
          return 1'b0;
        end
        acc = (lhs * 65536) / rhs;
      end
      OP_MOD: begin
        // Integer parts truncate toward zero; remainder follows the left sign.
        li = int'(lhs / 65536);
        ri = int'(rhs / 65536);
        if (ri == 0) begin
          eval_err = ST_DIVZERO;
          return 1'b0;
        end
        acc = longint'(li % ri) * 65536;
      end
      default: begin
        eval_err = ST_ILLEGAL;
        return 1'b0;
      end
    endcase
    eval_count--;
    eval_stack[eval_count-1] = clamp_q16(acc);
    return 1'b0;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic signed [31:0] val,
                                  input int reps, input bit typed,
                                  input logic signed [31:0] exp_val, input logic [2:0] exp_st);
    token_row_t row;
    row = '{op, val, reps, typed, exp_val, exp_st};
    token_table.push_back(row);
  endfunction

  // Send one token: idle at random, hold valid and payload until the
  // transaction, then predict. Valid stays high on return; the caller
  // either sends the next token or lowers it in the same step.
  task automatic send_token(input logic [2:0] op, input logic signed [31:0] val,
                            input bit typed, input out_item_t typed_res);
    in_item_t  tok;
    out_item_t res;
    while (sender_idles && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    tok.operation    = op;
    tok.number_value = val;
    in_valid_i <= 1'b1;
    in_data_i  <= tok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tokens_sent++;
    if (evaluate_token(tok, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  // Hold the sender off until every expected result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random Q16.16 operand: mostly small values, with extremes, pure
  // fractions (zero integer part for modulo) and full-range patterns.
  function automatic logic signed [31:0] rand_q16();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = 32'sh0000_0000;
          3:       v = 32'shFFFF_FFFF;
          default: v = 32'sh0000_0001;
        endcase
      end
      2: v = $urandom_range(0, 65535);
      default: v = ($urandom_range(0, 40) << 16) | ($urandom_range(0, 3) << 14);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic logic [2:0] rand_operator();
    if ($urandom_range(0, 19) == 0) return OP_ILLEGAL;
    return 3'($urandom_range(OP_ADD, OP_MOD));
  endfunction

  // One expression: mostly well-formed RPN with random content; some get
  // stray tokens or end early, and a rare deep one drives the stack toward full.
  task automatic send_random_expression();
    int noise, depth, pushes_left, push_bias;
    noise       = $urandom_range(0, 99);
    depth       = 0;
    pushes_left = $urandom_range(0, 6);
    push_bias   = 50;
    if ($urandom_range(0, 39) == 0) begin
      pushes_left = $urandom_range(120, 132);
      push_bias   = 97;
    end
    while (pushes_left > 0 || depth > 1) begin
      if (pushes_left > 0 && (depth < 2 || $urandom_range(0, 99) < push_bias)) begin
        send_token(OP_PUSH, rand_q16(), 1'b0, '0);
        depth++;
        pushes_left--;
      end else begin
        send_token(rand_operator(), $urandom, 1'b0, '0);
        depth--;
      end
      if (noise < 10 && $urandom_range(0, 5) == 0)
        send_token(3'($urandom_range(0, 7)), $urandom, 1'b0, '0);
      if (noise >= 10 && noise < 16 && $urandom_range(0, 3) == 0) break;
    end
    send_token(OP_END, $urandom, 1'b0, '0);
  endtask

  task automatic run_random_until(input int limit);
    while (tokens_sent < limit) send_random_expression();
  endtask

  // Receiver: accept results with random stalls and check each against
  // the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_value=%0d status=%0d",
               out_data_o.result_value, out_data_o.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.result_value !== want.result_value) begin
          $error("result_value: expected %0d, actual %0d",
                 want.result_value, out_data_o.result_value);
          error_count++;
        end
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
          error_count++;
        end
      end
    end
    out_ready_i <= !receiver_idles || ($urandom_range(0, 99) >= 25);
  end

  // Cycle limit: a hung handshake ends the run here.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("tb_postfix_stack_evaluator_unit: done, errors");
    $finish;
  end

  initial begin
    out_item_t typed_res;

    // Empty expression straight out of reset.
    add_row(OP_END,     32'sh0,         1,   1'b1, 32'sh0,         ST_EMPTY);
    // Add and subtract saturate at the Q16.16 extremes.
    add_row(OP_PUSH,    32'sh7FFF_FFFF, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_PUSH,    32'sh7FFF_FFFF, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_ADD,     32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_END,     32'sh0,         1,   1'b1, 32'sh7FFF_FFFF, ST_OK);
    add_row(OP_PUSH,    32'sh8000_0000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_PUSH,    32'sh7FFF_FFFF, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_SUB,     32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_END,     32'sh0,         1,   1'b1, 32'sh8000_0000, ST_OK);
    // 3.0 * -1.5, then times one LSB: the product floors toward minus infinity.
    add_row(OP_PUSH,    32'sh0003_0000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_PUSH,    32'shFFFE_8000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_MUL,     32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_PUSH,    32'sh0000_0001, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_MUL,     32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_END,     32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    // 7.0 / -2.0 gives a negative quotient.
    add_row(OP_PUSH,    32'sh0007_0000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_PUSH,    32'shFFFE_0000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_DIV,     32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_END,     32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    // Divide by zero.
    add_row(OP_PUSH,    32'sh0007_0000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_PUSH,    32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_DIV,     32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_END,     32'sh0,         1,   1'b1, 32'sh0,         ST_DIVZERO);
    // -7.5 mod 2.25 on integer parts: remainder takes the left sign.
    add_row(OP_PUSH,    32'shFFF8_8000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_PUSH,    32'sh0002_4000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_MOD,     32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_END,     32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    // Modulo by 0.5: the right integer part is zero.
    add_row(OP_PUSH,    32'sh0005_0000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_PUSH,    32'sh0000_8000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_MOD,     32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_END,     32'sh0,         1,   1'b1, 32'sh0,         ST_DIVZERO);
    // Operator on an empty stack.
    add_row(OP_ADD,     32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_END,     32'sh0,         1,   1'b1, 32'sh0,         ST_FEW);
    // Illegal operator with two operands.
    add_row(OP_PUSH,    32'sh0001_0000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_PUSH,    32'sh0002_0000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_ILLEGAL, 32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_END,     32'sh0,         1,   1'b1, 32'sh0,         ST_ILLEGAL);
    // Illegal operator with one operand is too few; later tokens are dropped.
    add_row(OP_PUSH,    32'sh0001_0000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_ILLEGAL, 32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_PUSH,    32'sh0002_0000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_ADD,     32'sh0,         1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_END,     32'sh0,         1,   1'b1, 32'sh0,         ST_FEW);
    // Two operands left at the end.
    add_row(OP_PUSH,    32'sh0001_0000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_PUSH,    32'sh0002_0000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_END,     32'sh0,         1,   1'b1, 32'sh0,         ST_MANY);
    // One push past a full stack.
    add_row(OP_PUSH,    32'sh5A5A_A5A5, DEPTH + 1, 1'b0, 32'sh0,   ST_OK);
    add_row(OP_END,     32'sh0,         1,   1'b1, 32'sh0,         ST_OVERFLOW);
    // Single most-negative operand comes back unchanged.
    add_row(OP_PUSH,    32'sh8000_0000, 1,   1'b0, 32'sh0,         ST_OK);
    add_row(OP_END,     32'sh0,         1,   1'b1, 32'sh8000_0000, ST_OK);

    // Hold reset, then release it at a rising edge.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table.
    foreach (token_table[i]) begin
      typed_res.result_value = token_table[i].exp_val;
      typed_res.status       = token_table[i].exp_st;
      repeat (token_table[i].reps)
        send_token(token_table[i].op, token_table[i].val, token_table[i].typed, typed_res);
    end
    drain_results();

    // Random expressions: idling on both sides, then a stretch with none, then idling again.
    tokens_sent = 0;
    run_random_until(RAND_TOKENS / 3);
    drain_results();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    run_random_until(2 * RAND_TOKENS / 3);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    run_random_until(RAND_TOKENS);

    // Let the last results out, then watch for strays.
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_postfix_stack_evaluator_unit: done, clean");
    end else begin
      $display("tb_postfix_stack_evaluator_unit: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
